>>> design/iee_pkg.sv
// Package for the infix expression evaluator: operator codes, error codes,
// controller/datapath command and status structs. No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package iee_pkg;

  localparam logic [2:0] OPC_ADD  = 3'd0;
  localparam logic [2:0] OPC_SUB  = 3'd1;
  localparam logic [2:0] OPC_MUL  = 3'd2;
  localparam logic [2:0] OPC_DIV  = 3'd3;
  localparam logic [2:0] OPC_LPAR = 3'd4;

  localparam logic [1:0] ERR_NONE = 2'd0;
  localparam logic [1:0] ERR_DIV0 = 2'd1;
  localparam logic [1:0] ERR_OVF  = 2'd2;
  localparam logic [1:0] ERR_MALF = 2'd3;

  localparam logic [7:0] CH_0     = 8'h30;
  localparam logic [7:0] CH_9     = 8'h39;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_STAR  = 8'h2A;
  localparam logic [7:0] CH_SLASH = 8'h2F;
  localparam logic [7:0] CH_LPAR  = 8'h28;
  localparam logic [7:0] CH_RPAR  = 8'h29;

  // datapath commands
  typedef struct packed {
    logic       take_char;   // latch char on transfer
    logic       digit;       // accumulate digit
    logic       flush;       // push number if any
    logic       push_op;     // push op_code
    logic       pop_op;      // drop top operator
    logic       ld_top;      // read top operator
    logic       alu_start;   // apply operator to two top values
    logic       set_err;
    logic [1:0] err;
    logic [2:0] op_code;
    logic       clear;       // back to reset state
  } iee_cmd_t;

  typedef struct packed {
    logic       err_set;
    logic       op_empty;
    logic       op_full;
    logic [2:0] op_top;
    logic       alu_busy;
    logic       alu_done;
    logic       val_one;
  } iee_sts_t;

  function automatic logic [1:0] prec(input logic [2:0] op);
    return (op == OPC_MUL || op == OPC_DIV) ? 2'd2 : 2'd1;
  endfunction

endpackage
`default_nettype wire

>>> design/iee_stream_if.sv
// Valid/ready stream interfaces for input characters and results.
// Uses no package.
`timescale 1ns / 1ps
`default_nettype none
interface iee_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] char_in;
  logic       last_char;
  modport source (output valid, char_in, last_char, input ready);
  modport sink   (input valid, char_in, last_char, output ready);
endinterface

interface iee_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] result_value;
  logic [1:0]         error_code;
  modport source (output valid, result_value, error_code, input ready);
  modport sink   (input valid, result_value, error_code, output ready);
endinterface
`default_nettype wire

>>> design/iee_divider.sv
// Iterative signed divider, one quotient bit per cycle, truncating toward zero.
// Depends on nothing.
`timescale 1ns / 1ps
`default_nettype none
module iee_divider (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        start_i,
  input  wire logic [31:0] dividend_i,
  input  wire logic [31:0] divisor_i,
  output logic             busy_o,
  output logic             done_o,
  output logic [31:0]      quotient_o
);
  logic [31:0] rem_q, rem_d, quo_q, quo_d, dvs_q, dvs_d;
  logic [5:0]  cnt_q, cnt_d;
  logic        neg_q, neg_d, busy_q, busy_d, done_q, done_d;
  logic [32:0] trial;
  logic [31:0] shifted;

  always_comb begin
    rem_d = rem_q; quo_d = quo_q; dvs_d = dvs_q; cnt_d = cnt_q;
    neg_d = neg_q; busy_d = busy_q; done_d = 1'b0;
    shifted = {rem_q[30:0], quo_q[31]};
    trial = {1'b0, shifted} - {1'b0, dvs_q};
    if (start_i) begin
      rem_d  = '0;
      quo_d  = dividend_i[31] ? 32'(-dividend_i) : dividend_i;
      dvs_d  = divisor_i[31] ? 32'(-divisor_i) : divisor_i;
      neg_d  = dividend_i[31] ^ divisor_i[31];
      cnt_d  = 6'd32;
      busy_d = 1'b1;
    end else if (busy_q) begin
      if (!trial[32]) begin
        rem_d = trial[31:0];
        quo_d = {quo_q[30:0], 1'b1};
      end else begin
        rem_d = shifted;
        quo_d = {quo_q[30:0], 1'b0};
      end
      cnt_d = cnt_q - 6'd1;
      if (cnt_q == 6'd1) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
    dvs_q <= dvs_d;
    neg_q <= neg_d;
  end

  assign busy_o     = busy_q;
  assign done_o     = done_q;
  assign quotient_o = neg_q ? 32'(-quo_q) : quo_q;
endmodule
`default_nettype wire

>>> design/iee_datapath.sv
// Datapath: number accumulator, operator and value stacks, ALU, sticky error.
// Depends on iee_pkg and iee_divider.
`timescale 1ns / 1ps
`default_nettype none
module iee_datapath #(
  parameter int OP_DEPTH    = 32,
  parameter int VALUE_DEPTH = 32
) (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire iee_pkg::iee_cmd_t cmd_i,
  input  wire logic [7:0]      char_i,
  output iee_pkg::iee_sts_t    sts_o,
  output logic [31:0]          value_o,
  output logic [1:0]           err_o
);
  localparam int OW = $clog2(OP_DEPTH + 1);
  localparam int VW = $clog2(VALUE_DEPTH + 1);
  localparam int OA = (OP_DEPTH > 1) ? $clog2(OP_DEPTH) : 1;
  localparam int VA = (VALUE_DEPTH > 1) ? $clog2(VALUE_DEPTH) : 1;

  logic [2:0]  op_mem [OP_DEPTH];
  logic [31:0] val_mem [VALUE_DEPTH];
  logic [OW-1:0] opc_q;
  logic [VW-1:0] vc_q;
  logic [31:0] acc_q, a_q, b_q, bottom_q, prod_q;
  logic        innum_q;
  logic [1:0]  err_q;
  logic [2:0]  top_q, alu_op_q;
  logic [7:0]  ch_q;
  logic [1:0]  alu_ph_q;   // 1: read operands, 2: compute, 3: write
  logic [31:0] alu_res;
  logic        div_start, div_busy, div_done;
  logic        div_special, div_wait;
  logic [31:0] div_q;
  logic        push_val;
  logic [31:0] push_data;
  logic        err_ok;

  assign err_ok = (err_q == iee_pkg::ERR_NONE);

  iee_divider u_div (
    .clk_i, .rst_ni, .start_i(div_start), .dividend_i(b_q), .divisor_i(a_q),
    .busy_o(div_busy), .done_o(div_done), .quotient_o(div_q)
  );

  // most negative value over minus one wraps to itself
  assign div_special = (b_q == 32'h8000_0000) && (a_q == 32'hFFFF_FFFF);
  assign div_wait    = (alu_op_q == iee_pkg::OPC_DIV) && (a_q != 32'd0) && !div_special;

  // start the divider once, on the first compute cycle
  assign div_start = (alu_ph_q == 2'd2) && div_wait && err_ok && !div_busy && !div_done;

  always_comb begin
    unique case (alu_op_q)
      iee_pkg::OPC_ADD: alu_res = b_q + a_q;
      iee_pkg::OPC_SUB: alu_res = b_q - a_q;
      iee_pkg::OPC_MUL: alu_res = prod_q;
      default:          alu_res = div_special ? b_q : div_q;
    endcase
  end

  // number flush push, or ALU result push
  always_comb begin
    push_val  = 1'b0;
    push_data = acc_q;
    if (cmd_i.flush && innum_q) push_val = 1'b1;
    else if (alu_ph_q == 2'd3) begin
      push_val  = 1'b1;
      push_data = alu_res;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      opc_q <= '0; vc_q <= '0; acc_q <= '0; innum_q <= 1'b0;
      err_q <= iee_pkg::ERR_NONE; alu_ph_q <= 2'd0;
    end else if (cmd_i.clear) begin
      opc_q <= '0; vc_q <= '0; acc_q <= '0; innum_q <= 1'b0;
      err_q <= iee_pkg::ERR_NONE; alu_ph_q <= 2'd0;
    end else begin
      if (cmd_i.digit) begin
        acc_q   <= 32'((acc_q << 3) + (acc_q << 1) + {24'd0, ch_q - iee_pkg::CH_0});
        innum_q <= 1'b1;
      end
      if (cmd_i.set_err && err_ok) err_q <= cmd_i.err;
      if (cmd_i.pop_op) opc_q <= opc_q - OW'(1);
      if (cmd_i.push_op && err_ok) begin
        if (opc_q >= OW'(OP_DEPTH)) err_q <= iee_pkg::ERR_OVF;
        else opc_q <= opc_q + OW'(1);
      end
      if (cmd_i.flush && innum_q) begin
        acc_q <= '0; innum_q <= 1'b0;
      end
      // ALU sequence
      unique case (alu_ph_q)
        2'd0: if (cmd_i.alu_start && err_ok) begin
          if (vc_q < VW'(2)) err_q <= iee_pkg::ERR_MALF;
          else alu_ph_q <= 2'd1;
        end
        2'd1: begin
          vc_q <= vc_q - VW'(2);
          alu_ph_q <= 2'd2;
        end
        2'd2: begin
          if (alu_op_q == iee_pkg::OPC_DIV && a_q == 32'd0) begin
            err_q <= iee_pkg::ERR_DIV0; alu_ph_q <= 2'd0;
          end else if (!div_wait) alu_ph_q <= 2'd3;
        end
        default: alu_ph_q <= 2'd0;
      endcase
      if (alu_ph_q == 2'd2 && div_done) alu_ph_q <= 2'd3;
      if (push_val && err_ok) begin
        if (vc_q >= VW'(VALUE_DEPTH)) err_q <= iee_pkg::ERR_OVF;
        else vc_q <= vc_q + VW'(1);
      end
    end
  end

  // stack memories, operand registers and the character and operator latches
  always_ff @(posedge clk_i) begin
    if (cmd_i.take_char) ch_q <= char_i;
    if (alu_ph_q == 2'd0 && cmd_i.alu_start) alu_op_q <= top_q;
    if (cmd_i.push_op && err_ok && opc_q < OW'(OP_DEPTH))
      op_mem[opc_q[OA-1:0]] <= cmd_i.op_code;
    if (cmd_i.ld_top) top_q <= op_mem[OA'(opc_q - OW'(1))];
    if (push_val && err_ok && vc_q < VW'(VALUE_DEPTH))
      val_mem[vc_q[VA-1:0]] <= push_data;
    if (alu_ph_q == 2'd0) a_q <= val_mem[VA'(vc_q - VW'(1))];
    if (alu_ph_q == 2'd1) b_q <= val_mem[VA'(vc_q - VW'(2))];
    if (alu_ph_q == 2'd2) prod_q <= 32'(b_q * a_q);
    bottom_q <= val_mem[0];
  end

  // a_q read in phase 0 is valid once phase 1 starts; b_q ready by phase 2
  assign sts_o.err_set  = !err_ok;
  assign sts_o.op_empty = (opc_q == '0);
  assign sts_o.op_full  = (opc_q >= OW'(OP_DEPTH));
  assign sts_o.op_top   = top_q;
  assign sts_o.alu_busy = (alu_ph_q != 2'd0) || div_busy;
  assign sts_o.alu_done = 1'b0;
  assign sts_o.val_one  = (vc_q == VW'(1));
  assign value_o = bottom_q;
  assign err_o   = err_q;
endmodule
`default_nettype wire

>>> design/iee_controller.sv
// Controller FSM: decodes characters, sequences stack pops and ALU steps.
// Depends on iee_pkg.
`timescale 1ns / 1ps
`default_nettype none
module iee_controller (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  output logic                   in_ready_o,
  input  wire logic [7:0]        char_i,
  input  wire logic              last_i,
  output logic                   out_valid_o,
  input  wire logic              out_ready_o_i,
  output iee_pkg::iee_cmd_t      cmd_o,
  input  wire iee_pkg::iee_sts_t sts_i,
  output logic                   cap_o
);
  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_DEC   = 4'd1;
  localparam logic [3:0] S_RTOP  = 4'd2;
  localparam logic [3:0] S_RCHK  = 4'd3;
  localparam logic [3:0] S_OTOP  = 4'd4;
  localparam logic [3:0] S_OCHK  = 4'd5;
  localparam logic [3:0] S_ALU   = 4'd6;
  localparam logic [3:0] S_ETOP  = 4'd7;
  localparam logic [3:0] S_ECHK  = 4'd8;
  localparam logic [3:0] S_FIN   = 4'd9;
  localparam logic [3:0] S_OUT   = 4'd10;
  localparam logic [3:0] S_WAIT  = 4'd11;

  logic [3:0] st_q, st_d, ret_q, ret_d;
  logic [7:0] ch_q;
  logic       last_q;
  logic [2:0] op_q;
  logic       is_op;
  logic [2:0] op_enc;

  always_comb begin
    is_op  = 1'b1;
    op_enc = iee_pkg::OPC_DIV;
    priority if (ch_q == iee_pkg::CH_PLUS)  op_enc = iee_pkg::OPC_ADD;
    else if (ch_q == iee_pkg::CH_MINUS) op_enc = iee_pkg::OPC_SUB;
    else if (ch_q == iee_pkg::CH_STAR)  op_enc = iee_pkg::OPC_MUL;
    else if (ch_q == iee_pkg::CH_SLASH) op_enc = iee_pkg::OPC_DIV;
    else is_op = 1'b0;
  end

  always_comb begin
    st_d  = st_q;
    ret_d = ret_q;
    cmd_o = '0;
    cmd_o.op_code = op_q;
    in_ready_o  = (st_q == S_IDLE);
    out_valid_o = (st_q == S_OUT);
    cmd_o.take_char = in_ready_o && in_valid_i;
    cap_o = 1'b0;
    unique case (st_q)
      S_IDLE: if (in_valid_i) st_d = S_DEC;
      S_DEC: begin
        st_d = last_q ? S_FIN : S_IDLE;
        if (!sts_i.err_set) begin
          if (ch_q >= iee_pkg::CH_0 && ch_q <= iee_pkg::CH_9) cmd_o.digit = 1'b1;
          else begin
            cmd_o.flush = 1'b1;
            if (ch_q == iee_pkg::CH_LPAR) begin
              cmd_o.push_op = 1'b1; cmd_o.op_code = iee_pkg::OPC_LPAR;
            end else if (ch_q == iee_pkg::CH_RPAR) begin
              cmd_o.ld_top = 1'b1; st_d = S_RCHK;
            end else if (is_op) begin
              cmd_o.ld_top = 1'b1; st_d = S_OCHK;
            end
          end
        end
      end
      S_RTOP: begin cmd_o.ld_top = 1'b1; st_d = S_RCHK; end
      S_RCHK: begin
        if (sts_i.err_set) st_d = last_q ? S_FIN : S_IDLE;
        else if (sts_i.op_empty) begin
          cmd_o.set_err = 1'b1; cmd_o.err = iee_pkg::ERR_MALF;
          st_d = last_q ? S_FIN : S_IDLE;
        end else begin
          cmd_o.pop_op = 1'b1;
          if (sts_i.op_top == iee_pkg::OPC_LPAR) st_d = last_q ? S_FIN : S_IDLE;
          else begin cmd_o.alu_start = 1'b1; ret_d = S_RTOP; st_d = S_ALU; end
        end
      end
      S_OTOP: begin cmd_o.ld_top = 1'b1; st_d = S_OCHK; end
      S_OCHK: begin
        if (!sts_i.err_set && !sts_i.op_empty && sts_i.op_top != iee_pkg::OPC_LPAR
            && iee_pkg::prec(sts_i.op_top) >= iee_pkg::prec(op_q)) begin
          cmd_o.pop_op = 1'b1; cmd_o.alu_start = 1'b1;
          ret_d = S_OTOP; st_d = S_ALU;
        end else begin
          cmd_o.push_op = 1'b1;
          st_d = last_q ? S_FIN : S_IDLE;
        end
      end
      S_ALU: if (!sts_i.alu_busy) st_d = ret_q;
      S_FIN: begin
        cmd_o.flush = 1'b1; cmd_o.ld_top = 1'b1; st_d = S_ECHK;
      end
      S_ETOP: begin cmd_o.ld_top = 1'b1; st_d = S_ECHK; end
      S_ECHK: begin
        if (sts_i.err_set) st_d = S_WAIT;
        else if (sts_i.op_empty) begin
          if (!sts_i.val_one) begin
            cmd_o.set_err = 1'b1; cmd_o.err = iee_pkg::ERR_MALF;
          end
          st_d = S_WAIT;
        end else begin
          cmd_o.pop_op = 1'b1;
          if (sts_i.op_top == iee_pkg::OPC_LPAR) begin
            cmd_o.set_err = 1'b1; cmd_o.err = iee_pkg::ERR_MALF; st_d = S_WAIT;
          end else begin cmd_o.alu_start = 1'b1; ret_d = S_ETOP; st_d = S_ALU; end
        end
      end
      S_WAIT: begin cap_o = 1'b1; st_d = S_OUT; end
      S_OUT: if (out_ready_o_i) begin cmd_o.clear = 1'b1; st_d = S_IDLE; end
      default: st_d = S_IDLE;
    endcase
    // an end-of-input ALU return with the error set skips the stack top re-read
    if (st_q == S_ALU && !sts_i.alu_busy && ret_q == S_ETOP && sts_i.err_set) st_d = S_WAIT;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q  <= S_IDLE;
      ret_q <= S_IDLE;
    end else begin
      st_q  <= st_d;
      ret_q <= ret_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_o.take_char) begin
      ch_q   <= char_i;
      last_q <= last_i;
    end
    if (st_q == S_DEC) op_q <= op_enc;
  end
endmodule
`default_nettype wire

>>> design/infix_expression_evaluator_top.sv
// Channel  Dir  Payload
// in_s     in   char_in[7:0], last_char
// out_m    out  result_value[31:0] signed, error_code[1:0]
//
// Each character is taken in S_IDLE and decoded in S_DEC; no new one is
// taken until it is handled. ")", an operator and the last character may
// also pop operators, each through the ALU phases; a divide waits on the
// iterative 1-bit-per-cycle divider. The result waits in its register until
// taken; no input is taken meanwhile. Reset is asynchronous and clears all
// control state; stacks need no clearing.
// Depends on iee_pkg, iee_stream_if, iee_controller, iee_datapath.
`timescale 1ns / 1ps
`default_nettype none
module infix_expression_evaluator_top #(
  parameter int OP_DEPTH    = 32,
  parameter int VALUE_DEPTH = 32
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  iee_in_if.sink    in_s,
  iee_out_if.source out_m
);
  iee_pkg::iee_cmd_t cmd;
  iee_pkg::iee_sts_t sts;
  logic [31:0] value;
  logic [1:0]  err;
  logic        cap;
  logic signed [31:0] res_q;
  logic [1:0]  code_q;

  iee_controller u_ctrl (
    .clk_i, .rst_ni,
    .in_valid_i(in_s.valid), .in_ready_o(in_s.ready),
    .char_i(in_s.char_in), .last_i(in_s.last_char),
    .out_valid_o(out_m.valid), .out_ready_o_i(out_m.ready),
    .cmd_o(cmd), .sts_i(sts), .cap_o(cap)
  );

  iee_datapath #(.OP_DEPTH(OP_DEPTH), .VALUE_DEPTH(VALUE_DEPTH)) u_dp (
    .clk_i, .rst_ni, .cmd_i(cmd), .char_i(in_s.char_in),
    .sts_o(sts), .value_o(value), .err_o(err)
  );

  always_ff @(posedge clk_i) begin
    if (cap) begin
      res_q  <= (err == iee_pkg::ERR_NONE) ? value : 32'sd0;
      code_q <= err;
    end
  end

  assign out_m.result_value = res_q;
  assign out_m.error_code   = code_q;
endmodule
`default_nettype wire

>>> dv/infix_expression_evaluator_top_tb.sv
// Testbench for infix_expression_evaluator_top: random and directed expressions,
// checked against an in-bench shunting-yard predictor.
// Depends on iee_pkg, iee_stream_if and the evaluator RTL.
`timescale 1ns / 1ps
module infix_expression_evaluator_top_tb;
  import iee_pkg::*;

  localparam int STK_DEPTH   = 32;
  localparam int CYCLE_LIMIT = 1000000;

  typedef struct {
    logic [7:0] c;
    logic       last;
  } char_item_t;

  typedef struct {
    logic signed [31:0] value;
    logic [1:0]         err;
  } eval_result_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  iee_in_if  in_if ();
  iee_out_if out_if ();

  infix_expression_evaluator_top DUT (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_s  (in_if),
    .out_m (out_if)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  char_item_t   pending_chars[$];
  eval_result_t expected_results[$];
  int  send_idle_pct = 0;
  int  recv_stall_pct = 0;
  bit  hold_send = 1'b0;
  int  fail_count = 0;
  int  results_seen = 0;
  int  chars_sent = 0;
  int  cycle_count = 0;

  // predictor state
  logic [31:0] p_accum;
  bit          p_in_num;
  logic [2:0]  p_ops[STK_DEPTH];
  int          p_op_n;
  logic [31:0] p_vals[STK_DEPTH];
  int          p_val_n;
  logic [1:0]  p_err;

  function automatic void p_clear();
    p_accum = '0; p_in_num = 0; p_op_n = 0; p_val_n = 0; p_err = ERR_NONE;
  endfunction

  function automatic void p_flag(logic [1:0] e);
    if (p_err == ERR_NONE) p_err = e;
  endfunction

  function automatic void p_push_val(logic [31:0] v);
    if (p_err != ERR_NONE) return;
    if (p_val_n >= STK_DEPTH) begin
      p_flag(ERR_OVF);
      return;
    end
    p_vals[p_val_n] = v;
    p_val_n++;
  endfunction

  function automatic void p_push_op(logic [2:0] op);
    if (p_err != ERR_NONE) return;
    if (p_op_n >= STK_DEPTH) begin
      p_flag(ERR_OVF);
      return;
    end
    p_ops[p_op_n] = op;
    p_op_n++;
  endfunction

  function automatic int rank(logic [2:0] op);
    return (op == OPC_MUL || op == OPC_DIV) ? 2 : 1;
  endfunction

  function automatic void p_apply(logic [2:0] op);
    logic [31:0] a, b, r;
    if (p_err != ERR_NONE) return;
    if (p_val_n < 2) begin
      p_flag(ERR_MALF);
      return;
    end
    a = p_vals[p_val_n-1];
    b = p_vals[p_val_n-2];
    p_val_n -= 2;
    case (op)
      OPC_ADD: r = b + a;
      OPC_SUB: r = b - a;
      OPC_MUL: r = b * a;
      default: begin
        if (a == 0) begin
          p_flag(ERR_DIV0);
          return;
        end
        if (b == 32'h8000_0000 && a == 32'hFFFF_FFFF) r = b;
        else r = $signed(b) / $signed(a);
      end
    endcase
    p_push_val(r);
  endfunction

  function automatic void p_flush();
    if (p_in_num) begin
      p_push_val(p_accum);
      p_accum = '0;
      p_in_num = 0;
    end
  endfunction

  function automatic void p_take(logic [7:0] c);
    logic [2:0] op;
    if (c >= CH_0 && c <= CH_9) begin
      p_accum = p_accum * 10 + 32'(c - CH_0);
      p_in_num = 1;
      return;
    end
    p_flush();
    if (c == CH_LPAR) begin
      p_push_op(OPC_LPAR);
    end else if (c == CH_RPAR) begin
      forever begin
        if (p_err != ERR_NONE) return;
        if (p_op_n == 0) begin
          p_flag(ERR_MALF);
          return;
        end
        p_op_n--;
        if (p_ops[p_op_n] == OPC_LPAR) return;
        p_apply(p_ops[p_op_n]);
      end
    end else if (c == CH_PLUS || c == CH_MINUS || c == CH_STAR || c == CH_SLASH) begin
      op = (c == CH_PLUS) ? OPC_ADD : (c == CH_MINUS) ? OPC_SUB :
           (c == CH_STAR) ? OPC_MUL : OPC_DIV;
      while (p_err == ERR_NONE && p_op_n > 0 && p_ops[p_op_n-1] != OPC_LPAR &&
             rank(p_ops[p_op_n-1]) >= rank(op)) begin
        p_op_n--;
        p_apply(p_ops[p_op_n]);
      end
      p_push_op(op);
    end
  endfunction

  // Advance the predictor by one transferred character.
  function automatic void predict_char(logic [7:0] c, logic last);
    eval_result_t r;
    if (p_err == ERR_NONE) p_take(c);
    if (!last) return;
    p_flush();
    while (p_err == ERR_NONE && p_op_n > 0) begin
      p_op_n--;
      if (p_ops[p_op_n] == OPC_LPAR) p_flag(ERR_MALF);
      else p_apply(p_ops[p_op_n]);
    end
    if (p_err == ERR_NONE && p_val_n != 1) p_flag(ERR_MALF);
    r.err = p_err;
    r.value = (p_err == ERR_NONE) ? p_vals[0] : '0;
    expected_results.push_back(r);
    p_clear();
  endfunction

  // driver
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_if.valid <= 1'b0;
      in_if.char_in <= '0;
      in_if.last_char <= 1'b0;
      p_clear();
    end else begin
      if (in_if.valid && in_if.ready) begin
        predict_char(in_if.char_in, in_if.last_char);
        chars_sent++;
      end
      if (!in_if.valid || in_if.ready) begin
        if (pending_chars.size() > 0 && !hold_send &&
            !($urandom_range(99) < send_idle_pct)) begin
          in_if.valid <= 1'b1;
          in_if.char_in <= pending_chars[0].c;
          in_if.last_char <= pending_chars[0].last;
          void'(pending_chars.pop_front());
        end else begin
          in_if.valid <= 1'b0;
        end
      end
    end
  end

  // monitor
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_if.ready <= 1'b0;
    end else begin
      if (out_if.valid && out_if.ready) begin
        results_seen++;
        if (expected_results.size() == 0) begin
          $error("unexpected result: value %0d error_code %0d",
                 out_if.result_value, out_if.error_code);
          fail_count++;
        end else begin
          if (out_if.result_value !== expected_results[0].value) begin
            $error("result_value: expected %0d actual %0d",
                   expected_results[0].value, out_if.result_value);
            fail_count++;
          end
          if (out_if.error_code !== expected_results[0].err) begin
            $error("error_code: expected %0d actual %0d",
                   expected_results[0].err, out_if.error_code);
            fail_count++;
          end
          void'(expected_results.pop_front());
        end
      end
      out_if.ready <= !($urandom_range(99) < recv_stall_pct);
    end
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("infix_expression_evaluator_top_tb NOT OK");
      $finish;
    end
  end

  // expression generators
  function automatic string gen_number();
    string s;
    int n;
    s = "";
    n = ($urandom_range(9) == 0) ? $urandom_range(12, 8) : $urandom_range(3, 1);
    repeat (n) s = {s, string'(8'(CH_0 + $urandom_range(9)))};
    return s;
  endfunction

  function automatic string gen_expr(int depth);
    string s;
    string ops;
    int n;
    ops = "+-*/";
    s = "";
    n = $urandom_range(3);
    for (int i = 0; i <= n; i++) begin
      if (i > 0) begin
        if ($urandom_range(7) == 0) s = {s, " "};
        s = {s, string'(ops[$urandom_range(3)])};
      end
      if (depth > 0 && $urandom_range(3) == 0) s = {s, "(", gen_expr(depth - 1), ")"};
      else if ($urandom_range(11) == 0) s = {s, "0"};
      else s = {s, gen_number()};
    end
    return s;
  endfunction

  function automatic string gen_broken();
    string s;
    string junk;
    int k;
    junk = "+-*/() 0";
    s = gen_expr(2);
    case ($urandom_range(4))
      0: s[$urandom_range(s.len() - 1)] = junk[$urandom_range(7)];
      1: s = s.substr(0, $urandom_range(s.len() - 1));
      2: s = {s, string'(junk[$urandom_range(7)])};
      3: begin
        k = $urandom_range(34, 30);
        repeat (k) s = {"(", s};
        repeat (k) s = {s, ")"};
      end
      default: begin
        k = $urandom_range(34, 30);
        s = "";
        repeat (k) s = {s, "1 "};
      end
    endcase
    return s;
  endfunction

  task automatic enqueue_expr(string s);
    char_item_t it;
    if (s.len() == 0) s = " ";
    for (int i = 0; i < s.len(); i++) begin
      it.c = s[i];
      it.last = (i == s.len() - 1);
      pending_chars.push_back(it);
    end
  endtask

  task automatic enqueue_noise();
    char_item_t it;
    int n;
    n = $urandom_range(8, 1);
    for (int i = 0; i < n; i++) begin
      it.c = 8'($urandom_range(255));
      it.last = (i == n - 1);
      pending_chars.push_back(it);
    end
  endtask

  task automatic fill_random(int n_chars);
    int target;
    int pick;
    target = pending_chars.size() + n_chars;
    while (pending_chars.size() < target) begin
      pick = $urandom_range(99);
      if (pick < 80) enqueue_expr(gen_expr(4));
      else if (pick < 90) enqueue_noise();
      else enqueue_expr(gen_broken());
    end
  endtask

  task automatic drain();
    wait (pending_chars.size() == 0 && expected_results.size() == 0 && !in_if.valid);
    repeat (100) @(posedge clk_i);
  endtask

  initial begin
    string deep;
    in_if.valid = 1'b0;
    in_if.char_in = '0;
    in_if.last_char = 1'b0;
    out_if.ready = 1'b0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: field extremes, each operator and each error path
    enqueue_expr("0");
    enqueue_expr("4294967295");
    enqueue_expr("99999999999");
    enqueue_expr("7-2*3+8/3");
    enqueue_expr("(1-8)/2");
    enqueue_expr("2147483648/4294967295");
    enqueue_expr("2*(3+4)*5");
    enqueue_expr("1/0");
    enqueue_expr("1/0+)");
    enqueue_expr("-1");
    enqueue_expr("1+");
    enqueue_expr(")");
    enqueue_expr("(1");
    enqueue_expr("");
    enqueue_expr("2 3");
    enqueue_expr("(2)3");
    enqueue_expr("12a3#4");
    deep = "";
    repeat (33) deep = {deep, "("};
    enqueue_expr({deep, "1"});
    deep = "";
    repeat (33) deep = {deep, "5 "};
    enqueue_expr(deep);
    enqueue_noise();
    drain();

    fill_random(250);
    wait (pending_chars.size() == 0);
    // hold off until every result is back
    hold_send = 1'b1;
    wait (expected_results.size() == 0);
    hold_send = 1'b0;
    fill_random(210);
    drain();

    send_idle_pct = 58;
    fill_random(460);
    drain();

    send_idle_pct = 0;
    recv_stall_pct = 58;
    fill_random(460);
    drain();

    send_idle_pct = 31;
    recv_stall_pct = 31;
    fill_random(460);
    drain();

    $display("sent %0d characters, checked %0d results over four idle/stall phases",
             chars_sent, results_seen);
    if (fail_count == 0 && expected_results.size() == 0) begin
      $display("infix_expression_evaluator_top_tb OK");
    end else begin
      $display("infix_expression_evaluator_top_tb NOT OK");
    end
    $finish;
  end

endmodule
